FILE: rtl/tmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_pkg
// Shared types and constants of the typed message mailbox: request and
// status codes, descriptor layout, sequencer states and scan modes.
// ----------------------------------------------------------------------------
package tmm_pkg;

    // field widths fixed by the request and response formats
    localparam int REQ_W       = 2;
    localparam int SEL_W       = 32;
    localparam int TYPE_W      = 31;
    localparam int LEN_W       = 16;
    localparam int HANDLE_W    = 32;
    localparam int FLAGS_W     = 2;
    localparam int STATUS_W    = 3;
    localparam int SLOT_OUT_W  = 5;
    localparam int COUNT_OUT_W = 6;
    localparam int BYTES_OUT_W = 21;

    // request codes
    localparam logic [REQ_W-1:0] REQ_SEND  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RECV  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_BADTYPE = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_TOOBIG  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOMSG   = 3'd4;

    // receive flag bit positions
    localparam int FLAG_TRUNC  = 0;
    localparam int FLAG_EXCEPT = 1;

    // reset value of the length limit
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd2048;

    // one stored message descriptor
    typedef struct packed {
        logic [TYPE_W-1:0]   mtype;
        logic [LEN_W-1:0]    len;
        logic [HANDLE_W-1:0] handle;
    } desc_t;

    // what the slot scan looks for
    typedef enum logic [2:0] {
        SM_FREE,
        SM_FIRST,
        SM_EQ,
        SM_NE,
        SM_MIN
    } scan_mode_t;

    // verdict of the compare unit on one slot
    typedef struct packed {
        logic hit;
        logic take;
    } match_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_RESOLVE
    } state_t;

endpackage

FILE: rtl/tmm_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm request and response channels
// Valid/ready channels carrying mailbox requests and their results.
// ----------------------------------------------------------------------------
interface tmm_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [31:0] msg_type;
    logic [15:0]        msg_len;
    logic [31:0]        payload_handle;
    logic [1:0]         recv_flags;

    modport source (
        output valid, req_type, msg_type, msg_len, payload_handle, recv_flags,
        input  ready
    );
    modport sink (
        input  valid, req_type, msg_type, msg_len, payload_handle, recv_flags,
        output ready
    );
endinterface

interface tmm_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [30:0] got_type;
    logic [31:0] got_handle;
    logic [15:0] got_len;
    logic [4:0]  slot_used;
    logic [5:0]  msg_count;
    logic [20:0] byte_count;

    modport source (
        output valid, status, got_type, got_handle, got_len, slot_used,
               msg_count, byte_count,
        input  ready
    );
    modport sink (
        input  valid, status, got_type, got_handle, got_len, slot_used,
               msg_count, byte_count,
        output ready
    );
endinterface

FILE: rtl/tmm_desc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_desc_ram
// Descriptor store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tmm_desc_ram
    import tmm_pkg::*;
#(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  desc_t             wdata,
    input  logic [ADDR_W-1:0] raddr,
    output desc_t             rdata
);

    desc_t mem [DEPTH];
    desc_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/tmm_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_match
// Shared compare unit: judges one slot against the current selector and,
// for the smallest-type search, against the best slot found so far.
// ----------------------------------------------------------------------------
module tmm_match
    import tmm_pkg::*;
(
    input  scan_mode_t        mode,
    input  logic [SEL_W-1:0]  mag,
    input  logic              slot_vld,
    input  logic [TYPE_W-1:0] slot_type,
    input  logic              have_best,
    input  logic [TYPE_W-1:0] best_type,
    output match_t            res
);

    logic type_eq;
    logic type_le;
    logic type_better;

    // compares against the selector and the running best
    assign type_eq     = ({1'b0, slot_type} == mag);
    assign type_le     = ({1'b0, slot_type} <= mag);
    assign type_better = !have_best || (slot_type < best_type);

    // verdict per scan mode
    always_comb
    begin
        res = '0;
        case (mode)
            SM_FREE:
            begin
                res.hit  = !slot_vld;
                res.take = !slot_vld;
            end
            SM_FIRST:
            begin
                res.hit  = slot_vld;
                res.take = slot_vld;
            end
            SM_EQ:
            begin
                res.hit  = slot_vld && type_eq;
                res.take = slot_vld && type_eq;
            end
            SM_NE:
            begin
                res.hit  = slot_vld && !type_eq;
                res.take = slot_vld && !type_eq;
            end
            SM_MIN:
            begin
                res.hit  = 1'b0;
                res.take = slot_vld && type_le && type_better;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

FILE: rtl/typed_message_mailbox_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_message_mailbox_top
// Message queue of SLOTS descriptors with send, selective receive and clear.
// A sequencer walks the slots one per cycle through a shared compare unit.
// ----------------------------------------------------------------------------
// sequencing: a send or receive scans the slots from the first one and stops at
//   a hit (never for a smallest-type receive); rejects and clears skip the scan
// requests: a new request is taken only in idle, once the previous one has
//   resolved; resolve waits while the output register still holds a result
// reset: queue empty, length limit 2048, no result pending; no clearing pass
module typed_message_mailbox_top
    import tmm_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata,
    tmm_req_if.sink       req,
    tmm_rsp_if.source     rsp
);

    localparam int IDX_W       = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int BYTES_W     = $clog2(SLOTS * 65535 + 1);
    localparam int SLOT_EXT_W  = (IDX_W > SLOT_OUT_W) ? IDX_W : SLOT_OUT_W;
    localparam int CNT_EXT_W   = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;
    localparam int BYTES_EXT_W = (BYTES_W > BYTES_OUT_W) ? BYTES_W : BYTES_OUT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // sequencer and request registers
    state_t                state_reg, state_next;
    logic [REQ_W-1:0]      op_reg, op_next;
    logic signed [SEL_W-1:0] sel_reg, sel_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [HANDLE_W-1:0]   handle_reg, handle_next;
    logic [FLAGS_W-1:0]    flags_reg, flags_next;
    logic [STATUS_W-1:0]   pre_status_reg, pre_status_next;
    logic [LEN_W-1:0]      max_len_reg;

    // queue state
    logic [SLOTS-1:0]      valid_reg, valid_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [BYTES_W-1:0]    bytes_reg, bytes_next;

    // scan registers
    scan_mode_t            mode_reg, mode_next;
    logic [SEL_W-1:0]      mag_reg, mag_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  issue_done_reg, issue_done_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  cmp_last_reg, cmp_last_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    desc_t                 best_reg, best_next;

    // output register
    logic                  out_vld_reg, out_vld_next;
    logic [STATUS_W-1:0]   o_status_reg, o_status_next;
    logic [TYPE_W-1:0]     o_type_reg, o_type_next;
    logic [HANDLE_W-1:0]   o_handle_reg, o_handle_next;
    logic [LEN_W-1:0]      o_len_reg, o_len_next;
    logic [SLOT_OUT_W-1:0] o_slot_reg, o_slot_next;
    logic [COUNT_OUT_W-1:0] o_cnt_reg, o_cnt_next;
    logic [BYTES_OUT_W-1:0] o_bytes_reg, o_bytes_next;

    // memory and compare unit hookup
    logic                  ram_we;
    desc_t                 ram_wdata;
    desc_t                 ram_rdata;
    match_t                match;

    // result assembly
    logic [SLOT_EXT_W-1:0]  slot_ext;
    logic [CNT_EXT_W-1:0]   cnt_ext;
    logic [BYTES_EXT_W-1:0] bytes_ext;
    logic                   out_free;

    tmm_desc_ram #(
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (best_idx_reg),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    tmm_match u_match (
        .mode      (mode_reg),
        .mag       (mag_reg),
        .slot_vld  (valid_reg[cmp_idx_reg]),
        .slot_type (ram_rdata.mtype),
        .have_best (found_reg),
        .best_type (best_reg.mtype),
        .res       (match)
    );

    assign ram_wdata = '{mtype: sel_reg[TYPE_W-1:0], len: len_reg, handle: handle_reg};
    assign out_free  = !out_vld_reg || rsp.ready;
    assign slot_ext  = SLOT_EXT_W'(best_idx_reg);
    assign cnt_ext   = CNT_EXT_W'(cnt_next);
    assign bytes_ext = BYTES_EXT_W'(bytes_next);

    // handshake outputs
    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_vld_reg;
    assign rsp.status     = o_status_reg;
    assign rsp.got_type   = o_type_reg;
    assign rsp.got_handle = o_handle_reg;
    assign rsp.got_len    = o_len_reg;
    assign rsp.slot_used  = o_slot_reg;
    assign rsp.msg_count  = o_cnt_reg;
    assign rsp.byte_count = o_bytes_reg;

    // length limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            cnt_reg     <= '0;
            bytes_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            cnt_reg     <= cnt_next;
            bytes_reg   <= bytes_next;
            cmp_vld_reg <= cmp_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        sel_reg        <= sel_next;
        len_reg        <= len_next;
        handle_reg     <= handle_next;
        flags_reg      <= flags_next;
        pre_status_reg <= pre_status_next;
        mode_reg       <= mode_next;
        mag_reg        <= mag_next;
        rd_idx_reg     <= rd_idx_next;
        issue_done_reg <= issue_done_next;
        cmp_idx_reg    <= cmp_idx_next;
        cmp_last_reg   <= cmp_last_next;
        found_reg      <= found_next;
        best_idx_reg   <= best_idx_next;
        best_reg       <= best_next;
        o_status_reg   <= o_status_next;
        o_type_reg     <= o_type_next;
        o_handle_reg   <= o_handle_next;
        o_len_reg      <= o_len_next;
        o_slot_reg     <= o_slot_next;
        o_cnt_reg      <= o_cnt_next;
        o_bytes_reg    <= o_bytes_next;
    end

    // sequencer: decode, slot scan, resolve
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        sel_next        = sel_reg;
        len_next        = len_reg;
        handle_next     = handle_reg;
        flags_next      = flags_reg;
        pre_status_next = pre_status_reg;
        valid_next      = valid_reg;
        cnt_next        = cnt_reg;
        bytes_next      = bytes_reg;
        mode_next       = mode_reg;
        mag_next        = mag_reg;
        rd_idx_next     = rd_idx_reg;
        issue_done_next = issue_done_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        cmp_last_next   = cmp_last_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        out_vld_next    = out_vld_reg && !rsp.ready;
        o_status_next   = o_status_reg;
        o_type_next     = o_type_reg;
        o_handle_next   = o_handle_reg;
        o_len_next      = o_len_reg;
        o_slot_next     = o_slot_reg;
        o_cnt_next      = o_cnt_reg;
        o_bytes_next    = o_bytes_reg;
        ram_we          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                // capture request beat
                if (req.valid)
                begin
                    op_next     = req.req_type;
                    sel_next    = req.msg_type;
                    len_next    = req.msg_len;
                    handle_next = req.payload_handle;
                    flags_next  = req.recv_flags;
                    state_next  = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                // pick scan mode and early rejects
                pre_status_next = STAT_OK;
                rd_idx_next     = '0;
                issue_done_next = 1'b0;
                found_next      = 1'b0;
                best_idx_next   = '0;
                mag_next        = sel_reg;
                mode_next       = SM_FREE;
                state_next      = ST_RESOLVE;
                if (op_reg == REQ_SEND)
                begin
                    if (sel_reg[SEL_W-1] || (sel_reg == '0))
                    begin
                        pre_status_next = STAT_BADTYPE;
                    end
                    else if (len_reg > max_len_reg)
                    begin
                        pre_status_next = STAT_TOOBIG;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
                else if (op_reg == REQ_RECV)
                begin
                    state_next = ST_SCAN;
                    if (sel_reg == '0)
                    begin
                        mode_next = SM_FIRST;
                    end
                    else if (!sel_reg[SEL_W-1])
                    begin
                        mode_next = flags_reg[FLAG_EXCEPT] ? SM_NE : SM_EQ;
                    end
                    else
                    begin
                        mode_next = SM_MIN;
                        mag_next  = ~sel_reg + 1'b1;
                    end
                end
            end

            ST_SCAN:
            begin
                // issue one slot read per cycle
                if (!issue_done_reg)
                begin
                    cmp_vld_next    = 1'b1;
                    cmp_idx_next    = rd_idx_reg;
                    cmp_last_next   = (rd_idx_reg == LAST_IDX);
                    issue_done_next = (rd_idx_reg == LAST_IDX);
                    rd_idx_next     = rd_idx_reg + 1'b1;
                end
                // judge the slot whose data just came back
                if (cmp_vld_reg)
                begin
                    if (match.take)
                    begin
                        found_next    = 1'b1;
                        best_idx_next = cmp_idx_reg;
                        best_next     = ram_rdata;
                    end
                    if (match.hit || cmp_last_reg)
                    begin
                        cmp_vld_next = 1'b0;
                        state_next   = ST_RESOLVE;
                    end
                end
            end

            ST_RESOLVE:
            begin
                // commit and load the result once the output stage is free
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    o_status_next = STAT_OK;
                    o_type_next   = '0;
                    o_handle_next = '0;
                    o_len_next    = '0;
                    o_slot_next   = '0;
                    case (op_reg)
                        REQ_SEND:
                        begin
                            if (pre_status_reg != STAT_OK)
                            begin
                                o_status_next = pre_status_reg;
                            end
                            else if (!found_reg)
                            begin
                                o_status_next = STAT_FULL;
                            end
                            else
                            begin
                                ram_we                   = 1'b1;
                                valid_next[best_idx_reg] = 1'b1;
                                cnt_next                 = cnt_reg + 1'b1;
                                bytes_next               = bytes_reg + BYTES_W'(len_reg);
                                o_slot_next              = slot_ext[SLOT_OUT_W-1:0];
                            end
                        end
                        REQ_RECV:
                        begin
                            if (!found_reg)
                            begin
                                o_status_next = STAT_NOMSG;
                            end
                            else if ((best_reg.len > len_reg) && !flags_reg[FLAG_TRUNC])
                            begin
                                o_status_next = STAT_TOOBIG;
                            end
                            else
                            begin
                                valid_next[best_idx_reg] = 1'b0;
                                cnt_next      = cnt_reg - 1'b1;
                                bytes_next    = bytes_reg - BYTES_W'(best_reg.len);
                                o_type_next   = best_reg.mtype;
                                o_handle_next = best_reg.handle;
                                o_len_next    = (best_reg.len > len_reg) ? len_reg
                                                                         : best_reg.len;
                                o_slot_next   = slot_ext[SLOT_OUT_W-1:0];
                            end
                        end
                        REQ_CLEAR:
                        begin
                            valid_next = '0;
                            cnt_next   = '0;
                            bytes_next = '0;
                        end
                        default:
                        begin
                            o_status_next = STAT_OK;
                        end
                    endcase
                    o_cnt_next   = cnt_ext[COUNT_OUT_W-1:0];
                    o_bytes_next = bytes_ext[BYTES_OUT_W-1:0];
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // message count tracks the occupied slots
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == cnt_reg)
        else $error("message count differs from occupied slots");

    // an empty queue holds no bytes
    a_empty_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (bytes_reg == '0))
        else $error("byte count nonzero with empty queue");

    // queue state only changes when a request resolves
    a_state_changes_on_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RESOLVE) |=> $stable(valid_reg) && $stable(cnt_reg))
        else $error("queue state changed outside resolve");

    // a result is loaded only from resolve
    a_result_from_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg) == ST_RESOLVE)
        else $error("result appeared without a resolve step");

endmodule
